>>> sv/gyro_fused_wheel_odometry_assert.svh
// Assertion macros used by the checker file.
`ifndef GYRO_FUSED_WHEEL_ODOMETRY_ASSERT_SVH
`define GYRO_FUSED_WHEEL_ODOMETRY_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define GFWO_ASSERT_IMPLY(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define GFWO_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");

// Next-cycle implication that also holds out of reset.
`define GFWO_ASSERT_NEXT_ANY(label, clk, a, b) \
   label: assert property (@(posedge clk) (a) |=> (b)) \
      else $error("assertion failed");

`endif

>>> sv/gfwo_pkg.sv
// ----------------------------------------------------------------------------
// gfwo_pkg
// Constants, types and the arctangent table of the gyro fused odometry block.
// ----------------------------------------------------------------------------
package gfwo_pkg;

   // Angles in Q15.16 radians
   localparam int signed PI_Q      = 205887;
   localparam int signed TWO_PI_Q  = 411775;
   localparam int signed HALF_PI_Q = 102944;

   // floor(2^36 / two pi in Q15.16), for the quotient estimate of the angle reduction
   localparam logic [17:0] MOD_RECIP = 18'd166885;

   // CORDIC start value in Q2.30
   localparam logic [33:0] CORDIC_GAIN = 34'd652032874;

   // Register indexes
   localparam logic [2:0] REG_INIT_X       = 3'd0;
   localparam logic [2:0] REG_INIT_Y       = 3'd1;
   localparam logic [2:0] REG_INIT_HEADING = 3'd2;
   localparam logic [2:0] REG_METERS_PER   = 3'd3;
   localparam logic [2:0] REG_INV_BASE     = 3'd4;
   localparam logic [2:0] REG_GYRO_THRESH  = 3'd5;

   // Item kinds
   localparam logic FUNC_UPDATE = 1'b0;
   localparam logic FUNC_LOAD   = 1'b1;

   // Status from the angle unit
   typedef struct packed {
      logic               done;
      logic signed [31:0] cos_v;
      logic signed [31:0] sin_v;
   } trig_type;

   // atan(2^-i) in Q2.30
   function automatic logic [30:0] atan_val(input logic [4:0] i);
      logic [30:0] v;
      case (i)
         5'd0:  v = 31'd843314857;
         5'd1:  v = 31'd497837829;
         5'd2:  v = 31'd263043837;
         5'd3:  v = 31'd133525159;
         5'd4:  v = 31'd67021687;
         5'd5:  v = 31'd33543516;
         5'd6:  v = 31'd16775851;
         5'd7:  v = 31'd8388437;
         5'd8:  v = 31'd4194283;
         5'd9:  v = 31'd2097149;
         5'd31: v = 31'd0;
         default: v = 31'd1 << (5'd30 - i);
      endcase
      return v;
   endfunction

endpackage

>>> sv/gyro_fused_wheel_odometry.sv
// ----------------------------------------------------------------------------
// gyro_fused_wheel_odometry
// Differential drive odometry with gyro heading fusion, Q15.16 fixed point.
// ----------------------------------------------------------------------------
// Update item: the result waits on the reciprocal angle reduction (A_MOD, A_REM)
// and the CORDIC loop; the shared
// 33x33 multiplier serves five products. Pose load: result valid in the cycle after accept.
// One item at a time; the next is taken the cycle after the result is delivered.
// Synchronous reset clears pose, last yaw and registers to their defaults.
module gyro_fused_wheel_odometry #(
   parameter int CORDIC_STEPS = 20
) (
   input  logic         clock,
   input  logic         reset,
   // tdata: left_count, left_prev_count, right_count, right_prev_count,
   //        gyro_yaw[19:0], zero pad
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [151:0] req_tdata,
   // tuser: func
   input  logic         req_tuser,
   // tdata: pos_x, pos_y, heading
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [95:0]  rsp_tdata,
   // tuser: used_gyro
   output logic         rsp_tuser,
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_wdata
);

   typedef enum logic [3:0] {
      S_IDLE, S_SL, S_SLW, S_SR, S_SRW, S_DP, S_DPW, S_PREP,
      S_ANGGO, S_ANG, S_DX, S_DXW, S_DY, S_DYW, S_OUT
   } state_type;

   state_type          state_ff;
   logic [31:0]        init_x_ff, init_y_ff, init_h_ff, mpc_ff, iwb_ff;
   logic [17:0]        thr_ff;
   logic [31:0]        pose_x_ff, pose_y_ff, pose_h_ff;
   logic [19:0]        last_yaw_ff;
   logic signed [31:0] lc_ff, lp_ff, rc_ff, rp_ff;
   logic signed [19:0] yaw_ff;
   logic signed [31:0] sl_ff, sr_ff, dpsi_ff, ds_ff, dhead_ff;
   logic signed [32:0] ang_ff;
   logic signed [65:0] prod_ff;
   logic               neg_ff, used_ff, rsp_valid_ff, start_ff;
   gfwo_pkg::trig_type trig;

   gfwo_angle_unit #(.STEPS(CORDIC_STEPS)) u_angle (
      .clock (clock),
      .reset (reset),
      .start (start_ff),
      .angle (ang_ff),
      .trig  (trig)
   );

   // Round half away from zero and saturate a Q16 product
   function automatic logic [31:0] round_sat(input logic [63:0] p, input logic neg);
      logic [48:0] r;
      logic [31:0] v;
      r = 49'(({1'b0, p} + 65'd32768) >> 16);
      if (!neg) v = (r > 49'h7FFFFFFF) ? 32'h7FFFFFFF : r[31:0];
      else      v = (r > 49'h80000000) ? 32'h80000000 : 32'(-r[31:0]);
      return v;
   endfunction

   // Encoder deltas and their magnitudes
   logic signed [32:0] dl, dr, ssum, sdiff;
   logic [32:0]        dl_mag, dr_mag, ssum_mag;
   always_comb begin
      dl       = 33'(lc_ff) - 33'(lp_ff);
      dr       = 33'(rc_ff) - 33'(rp_ff);
      dl_mag   = dl[32] ? 33'(-dl) : 33'(dl);
      dr_mag   = dr[32] ? 33'(-dr) : 33'(dr);
      ssum     = 33'(sr_ff) + 33'(sl_ff);
      ssum_mag = ssum[32] ? 33'(-ssum) : 33'(ssum);
      sdiff    = 33'(sr_ff) - 33'(sl_ff);
   end

   // Shared multiplier
   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] mul_p;
   always_comb begin
      case (state_ff)
         S_SL: begin
            mul_a = $signed({1'b0, dl_mag[31:0]});
            mul_b = $signed({1'b0, mpc_ff});
         end
         S_SR: begin
            mul_a = $signed({1'b0, dr_mag[31:0]});
            mul_b = $signed({1'b0, mpc_ff});
         end
         S_DP: begin
            mul_a = $signed({1'b0, ssum_mag[31:0]});
            mul_b = $signed({1'b0, iwb_ff});
         end
         S_DX: begin
            mul_a = 33'(ds_ff);
            mul_b = 33'(trig.cos_v);
         end
         S_DY: begin
            mul_a = 33'(ds_ff);
            mul_b = 33'(trig.sin_v);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_p = mul_a * mul_b;
   end

   // Yaw wrap, gyro step and heading choice
   logic signed [20:0] cur_yaw, prev_yaw, yaw_s, last_s, dgyro;
   logic signed [33:0] go, go_abs;
   logic signed [32:0] hsum;
   logic signed [31:0] half_dpsi, ds_in;
   logic               used_in;
   logic signed [65:0] rnd;
   always_comb begin
      yaw_s    = 21'(yaw_ff);
      last_s   = 21'($signed(last_yaw_ff));
      cur_yaw  = yaw_s;
      if (yaw_s > 21'(gfwo_pkg::PI_Q)) cur_yaw = yaw_s - 21'(gfwo_pkg::TWO_PI_Q);
      else if (yaw_s < -21'(gfwo_pkg::PI_Q)) cur_yaw = yaw_s + 21'(gfwo_pkg::TWO_PI_Q);
      prev_yaw = last_s;
      if (last_s > 21'(gfwo_pkg::PI_Q)) prev_yaw = last_s - 21'(gfwo_pkg::TWO_PI_Q);
      else if (last_s < -21'(gfwo_pkg::PI_Q)) prev_yaw = last_s + 21'(gfwo_pkg::TWO_PI_Q);
      dgyro     = cur_yaw - prev_yaw;
      go        = 34'(dgyro) - 34'(dpsi_ff);
      go_abs    = go[33] ? -go : go;
      used_in   = (go_abs > 34'(thr_ff)) && (go_abs < 34'(gfwo_pkg::PI_Q));
      // halve toward zero
      hsum      = 33'(dpsi_ff) + $signed({32'd0, dpsi_ff[31]});
      half_dpsi = 32'(hsum >>> 1);
      ds_in     = 32'((sdiff + 33'(sdiff[32])) >>> 1);
      rnd       = (prod_ff + 66'sd536870912) >>> 30;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         start_ff     <= 1'b0;
         init_x_ff    <= '0;
         init_y_ff    <= '0;
         init_h_ff    <= '0;
         mpc_ff       <= 32'd671088;
         iwb_ff       <= 32'd312827;
         thr_ff       <= 18'd3431;
         pose_x_ff    <= '0;
         pose_y_ff    <= '0;
         pose_h_ff    <= '0;
         last_yaw_ff  <= '0;
         used_ff      <= 1'b0;
      end else begin
         start_ff <= 1'b0;
         // Register writes
         if (csr_we) begin
            case (csr_index)
               gfwo_pkg::REG_INIT_X:       init_x_ff <= csr_wdata;
               gfwo_pkg::REG_INIT_Y:       init_y_ff <= csr_wdata;
               gfwo_pkg::REG_INIT_HEADING: init_h_ff <= csr_wdata;
               gfwo_pkg::REG_METERS_PER:   mpc_ff    <= csr_wdata;
               gfwo_pkg::REG_INV_BASE:     iwb_ff    <= csr_wdata;
               gfwo_pkg::REG_GYRO_THRESH:  thr_ff    <= csr_wdata[17:0];
               default: ;
            endcase
         end
         // Sequencer
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  lc_ff  <= req_tdata[31:0];
                  lp_ff  <= req_tdata[63:32];
                  rc_ff  <= req_tdata[95:64];
                  rp_ff  <= req_tdata[127:96];
                  yaw_ff <= req_tdata[147:128];
                  if (req_tuser == gfwo_pkg::FUNC_LOAD) begin
                     pose_x_ff    <= init_x_ff;
                     pose_y_ff    <= init_y_ff;
                     pose_h_ff    <= init_h_ff;
                     used_ff      <= 1'b0;
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= S_OUT;
                  end else begin
                     state_ff <= S_SL;
                  end
               end
            end
            S_SL: begin
               prod_ff  <= mul_p;
               neg_ff   <= dl[32];
               state_ff <= S_SLW;
            end
            S_SLW: begin
               sl_ff    <= round_sat(prod_ff[63:0], neg_ff);
               state_ff <= S_SR;
            end
            S_SR: begin
               prod_ff  <= mul_p;
               neg_ff   <= dr[32];
               state_ff <= S_SRW;
            end
            S_SRW: begin
               sr_ff    <= round_sat(prod_ff[63:0], neg_ff);
               state_ff <= S_DP;
            end
            S_DP: begin
               // A sum of magnitude 2^32 is the only one needing bit 32
               prod_ff  <= ssum_mag[32] ? $signed({2'b00, iwb_ff, 32'd0}) : mul_p;
               neg_ff   <= ssum[32];
               state_ff <= S_DPW;
            end
            S_DPW: begin
               dpsi_ff  <= round_sat(prod_ff[63:0], neg_ff);
               ds_ff    <= ds_in;
               state_ff <= S_PREP;
            end
            S_PREP: begin
               ang_ff      <= 33'($signed(pose_h_ff)) + 33'(half_dpsi);
               used_ff     <= used_in;
               dhead_ff    <= used_in ? 32'(dgyro) : dpsi_ff;
               last_yaw_ff <= cur_yaw[19:0];
               state_ff    <= S_ANGGO;
            end
            S_ANGGO: begin
               start_ff <= 1'b1;
               state_ff <= S_ANG;
            end
            S_ANG: begin
               if (trig.done) state_ff <= S_DX;
            end
            S_DX: begin
               prod_ff  <= mul_p;
               state_ff <= S_DXW;
            end
            S_DXW: begin
               pose_x_ff <= pose_x_ff + rnd[31:0];
               state_ff  <= S_DY;
            end
            S_DY: begin
               prod_ff  <= mul_p;
               state_ff <= S_DYW;
            end
            S_DYW: begin
               pose_y_ff    <= pose_y_ff + rnd[31:0];
               pose_h_ff    <= pose_h_ff + dhead_ff;
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_OUT;
            end
            S_OUT: begin
               if (rsp_tready) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {pose_h_ff, pose_y_ff, pose_x_ff};
   assign rsp_tuser  = used_ff;

endmodule

>>> sv/gfwo_angle_unit.sv
// ----------------------------------------------------------------------------
// gfwo_angle_unit
// Reduces an angle modulo two pi by reciprocal multiply, folds it, then runs
// a CORDIC.
// ----------------------------------------------------------------------------
module gfwo_angle_unit #(
   parameter int STEPS = 20
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic signed [32:0]     angle,
   output gfwo_pkg::trig_type     trig
);

   localparam int IW = $clog2(STEPS);

   typedef enum logic [2:0] {A_IDLE, A_MOD, A_REM, A_FOLD, A_ROT} astate_type;

   astate_type         state_ff;
   logic [32:0]        mag_ff;
   logic [14:0]        q_ff;
   logic [19:0]        rem_ff;
   logic               neg_ff;
   logic               flip_ff;
   logic signed [33:0] x_ff, y_ff, z_ff;
   logic [IW-1:0]      i_ff;
   logic               done_ff;
   logic signed [31:0] cos_ff, sin_ff;

   // Quotient estimate (low by at most one) and remainder below twice two pi
   logic [38:0] qprod;
   logic [32:0] qmul;
   logic [19:0] rem_in;
   always_comb begin
      qprod  = 39'(mag_ff[32:12]) * 39'(gfwo_pkg::MOD_RECIP);
      qmul   = 33'(q_ff) * 33'(gfwo_pkg::TWO_PI_Q);
      rem_in = 20'(mag_ff - qmul);
   end

   // Final correction, then range fold to [-pi/2, pi/2]
   logic [18:0]        rem_c;
   logic signed [20:0] r0, r1, r2, r3;
   logic               flip_in;
   always_comb begin
      rem_c = (rem_ff >= 20'(gfwo_pkg::TWO_PI_Q)) ?
              19'(rem_ff - 20'(gfwo_pkg::TWO_PI_Q)) : rem_ff[18:0];
      r0 = neg_ff ? -$signed({2'b00, rem_c}) : $signed({2'b00, rem_c});
      r1 = r0;
      if (r1 > 21'(gfwo_pkg::PI_Q)) r1 = r0 - 21'(gfwo_pkg::TWO_PI_Q);
      r2 = r1;
      if (r1 < -21'(gfwo_pkg::PI_Q)) r2 = r1 + 21'(gfwo_pkg::TWO_PI_Q);
      r3 = r2;
      flip_in = 1'b0;
      if (r2 > 21'(gfwo_pkg::HALF_PI_Q)) begin
         r3 = r2 - 21'(gfwo_pkg::PI_Q);
         flip_in = 1'b1;
      end else if (r2 < -21'(gfwo_pkg::HALF_PI_Q)) begin
         r3 = r2 + 21'(gfwo_pkg::PI_Q);
         flip_in = 1'b1;
      end
   end

   // One CORDIC rotation
   logic signed [33:0] xs, ys, at;
   logic signed [33:0] x_in, y_in, z_in;
   always_comb begin
      xs = x_ff >>> i_ff;
      ys = y_ff >>> i_ff;
      at = $signed({3'b000, gfwo_pkg::atan_val(5'(i_ff))});
      if (z_ff >= 0) begin
         x_in = x_ff - ys;
         y_in = y_ff + xs;
         z_in = z_ff - at;
      end else begin
         x_in = x_ff + ys;
         y_in = y_ff - xs;
         z_in = z_ff + at;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            A_IDLE: begin
               if (start) begin
                  neg_ff   <= angle[32];
                  mag_ff   <= angle[32] ? 33'(-angle) : 33'(angle);
                  state_ff <= A_MOD;
               end
            end
            A_MOD: begin
               q_ff     <= qprod[38:24];
               state_ff <= A_REM;
            end
            A_REM: begin
               rem_ff   <= rem_in;
               state_ff <= A_FOLD;
            end
            A_FOLD: begin
               flip_ff  <= flip_in;
               z_ff     <= 34'(r3) <<< 14;
               x_ff     <= $signed(gfwo_pkg::CORDIC_GAIN);
               y_ff     <= '0;
               i_ff     <= '0;
               state_ff <= A_ROT;
            end
            A_ROT: begin
               x_ff <= x_in;
               y_ff <= y_in;
               z_ff <= z_in;
               i_ff <= i_ff + 1'b1;
               if (i_ff == IW'(STEPS - 1)) begin
                  cos_ff   <= flip_ff ? 32'(-x_in) : 32'(x_in);
                  sin_ff   <= flip_ff ? 32'(-y_in) : 32'(y_in);
                  done_ff  <= 1'b1;
                  state_ff <= A_IDLE;
               end
            end
            default: state_ff <= A_IDLE;
         endcase
      end
   end

   assign trig.done  = done_ff;
   assign trig.cos_v = cos_ff;
   assign trig.sin_v = sin_ff;

endmodule

>>> sv/gfwo_checker.sv
// ----------------------------------------------------------------------------
// gfwo_checker
// Port-level checks of the gyro fused odometry block, bound to the top level.
// ----------------------------------------------------------------------------
`include "gyro_fused_wheel_odometry_assert.svh"

module gfwo_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [95:0]  rsp_tdata,
   input logic         rsp_tuser
);

   // One item in flight: no intake while a result waits
   `GFWO_ASSERT_IMPLY(a_no_overlap, clock, reset, rsp_tvalid, !req_tready)

   // An accepted item closes the intake on the next cycle
   `GFWO_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready)

   // A delivered result is not shown twice
   `GFWO_ASSERT_NEXT(a_single_result, clock, reset, rsp_tvalid && rsp_tready, !rsp_tvalid)

   // A stalled result holds its payload
   `GFWO_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // Reset leaves no result pending
   `GFWO_ASSERT_NEXT_ANY(a_reset_clear, clock, reset, !rsp_tvalid)

endmodule

bind gyro_fused_wheel_odometry gfwo_checker u_gfwo_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
